// ===== src/hmn_pkg.sv =====
// hmn_pkg: shared constants, codes and controller/datapath link types
// for the height map to normal map unit
// no dependencies
package hmn_pkg;

	// image geometry, one store entry per pixel, index row*MAX_COLUMNS+col
	localparam int COL_W       = 6;
	localparam int ROW_W       = 6;
	localparam int MAX_COLUMNS = 1 << COL_W;
	localparam int MAX_ROWS    = 1 << ROW_W;
	localparam int ADDR_W      = COL_W + ROW_W;
	localparam int DEPTH       = MAX_COLUMNS * MAX_ROWS;
	localparam int HGT_W       = 15;

	// stream payload widths
	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 48;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd2;
	localparam logic [6:0]  COLUMNS_RST = 7'd64;
	localparam logic [6:0]  ROWS_RST    = 7'd64;
	localparam logic [15:0] SCALE_RST   = 16'd655;

	// action codes
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_QUERY = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// neighbour order of the four reads
	localparam logic [1:0] NB_LEFT  = 2'd0;
	localparam logic [1:0] NB_RIGHT = 2'd1;
	localparam logic [1:0] NB_UP    = 2'd2;
	localparam logic [1:0] NB_DOWN  = 2'd3;

	// z term: 65536*100, and its square
	localparam logic [22:0] NORM_D    = 23'd6553600;
	localparam logic [63:0] NORM_D_SQ = 64'd42949672960000;

	// controller to datapath
	typedef struct packed {
		logic       accept;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       cap_en;
		logic [1:0] cap_sel;
		logic       mul_slope;
		logic       mul_sq;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       div_init;
		logic       div_step;
		logic       out_load;
	} hmn_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic start_query;
	} hmn_sts_t;

endpackage

// ===== src/hmn_ctrl.sv =====
// hmn_ctrl: sequencer for the normal map unit, handshakes and command issue
// depends on hmn_pkg
module hmn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  hmn_pkg::hmn_sts_t sts,
	output hmn_pkg::hmn_cmd_t cmd
);
	import hmn_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_READ  = 4'd1;
	localparam logic [3:0] ST_MULA  = 4'd2;
	localparam logic [3:0] ST_MULSQ = 4'd3;
	localparam logic [3:0] ST_SQINI = 4'd4;
	localparam logic [3:0] ST_SQRT  = 4'd5;
	localparam logic [3:0] ST_DVINI = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0] state_q;
	logic [4:0] cnt_q;
	logic       m_tvalid_q;
	logic       accept;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign m_tvalid = m_tvalid_q;
	assign out_free = ~m_tvalid_q | m_tready;

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.rd_sel    = cnt_q[1:0];
		cmd.cap_sel   = 2'(cnt_q - 5'd1);
		case (state_q)
			ST_READ: begin
				cmd.rd_en  = (cnt_q < 5'd4);
				cmd.cap_en = (cnt_q != 5'd0);
			end
			ST_MULA:  cmd.mul_slope = 1'b1;
			ST_MULSQ: cmd.mul_sq    = 1'b1;
			ST_SQINI: cmd.sqrt_init = 1'b1;
			ST_SQRT:  cmd.sqrt_step = 1'b1;
			ST_DVINI: cmd.div_init  = 1'b1;
			ST_DIV:   cmd.div_step  = 1'b1;
			ST_DONE:  cmd.out_load  = out_free;
			default: ;
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && sts.start_query) state_q <= ST_READ;
				end
				ST_READ: begin
					if (cnt_q == 5'd4) begin
						cnt_q   <= '0;
						state_q <= ST_MULA;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_MULA:  state_q <= ST_MULSQ;
				ST_MULSQ: state_q <= ST_SQINI;
				ST_SQINI: state_q <= ST_SQRT;
				ST_SQRT: begin
					if (cnt_q == 5'd31) begin
						cnt_q   <= '0;
						state_q <= ST_DVINI;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_DVINI: state_q <= ST_DIV;
				ST_DIV: begin
					if (cnt_q == 5'd15) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

endmodule

// ===== src/hmn_dp.sv =====
// hmn_dp: datapath of the normal map unit: height store, maximum, slopes,
// bit-serial square root, three shared-step dividers, output register
// depends on hmn_pkg
module hmn_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hmn_pkg::hmn_cmd_t                   cmd,
	output hmn_pkg::hmn_sts_t                   sts,
	input  logic [hmn_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic [hmn_pkg::IN_USER_W-1:0]       s_tuser,
	input  logic                                cfg_we,
	input  logic [hmn_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [hmn_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output logic [hmn_pkg::OUT_DATA_W-1:0]      m_tdata
);
	import hmn_pkg::*;

	logic [6:0]  cols_q, rows_q;
	logic [15:0] scale_q;
	logic [6:0]  cols_eff, rows_eff;

	logic [COL_W-1:0] in_col;
	logic [ROW_W-1:0] in_row;
	logic [7:0]       in_red, in_green, in_blue;
	logic [1:0]       in_act;
	logic             in_bounds;
	logic [HGT_W-1:0] in_hgt;

	logic [HGT_W-1:0] mem [DEPTH];
	logic [HGT_W-1:0] rd_data_q;
	logic [HGT_W-1:0] max_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [3:0]       oob_q;
	logic [HGT_W-1:0] hgt_q [4];
	logic [ADDR_W-1:0] rd_addr;

	logic signed [15:0] dx, dy;
	logic [14:0]        dx_abs, dy_abs;
	logic [30:0]        a_mag_s1, b_mag_s1;
	logic               a_pos_s1, b_pos_s1;
	logic [61:0]        a_sq_s2, b_sq_s2;

	logic [63:0] sq_v_q, sq_r_q, sq_bit_q, sq_trial;

	logic [33:0] dvs_q;
	logic [33:0] rem_q [3];
	logic [15:0] quo_q [3];
	logic [30:0] lane_mag [3];
	logic [47:0] lane_num [3];
	logic [34:0] lane_t   [3];

	logic [14:0] qs [3];
	logic [15:0] nx, ny;
	logic [OUT_DATA_W-1:0] out_q;

	// configuration registers and clamped image size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q  <= COLUMNS_RST;
			rows_q  <= ROWS_RST;
			scale_q <= SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_COLUMNS: cols_q  <= cfg_wdata[6:0];
				CFG_ROWS:    rows_q  <= cfg_wdata[6:0];
				CFG_SCALE:   scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cols_eff = (cols_q == 7'd0) ? 7'd1 :
	                  (cols_q > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : cols_q;
	assign rows_eff = (rows_q == 7'd0) ? 7'd1 :
	                  (rows_q > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_q;

	// input beat fields
	assign in_col    = s_tdata[5:0];
	assign in_row    = s_tdata[11:6];
	assign in_red    = s_tdata[19:12];
	assign in_green  = s_tdata[27:20];
	assign in_blue   = s_tdata[35:28];
	assign in_act    = s_tuser;
	assign in_bounds = (7'(in_col) < cols_eff) && (7'(in_row) < rows_eff);
	assign in_hgt    = 15'(15'd33 * 15'(in_red)) + 15'(15'd66 * 15'(in_green))
	                 + 15'(15'd11 * 15'(in_blue));

	assign sts.start_query = (in_act == ACT_QUERY) && in_bounds;

	// running maximum height
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
		end else if (cmd.accept) begin
			if (in_act == ACT_CLEAR) begin
				max_q <= '0;
			end else if (in_act == ACT_LOAD && in_bounds && in_hgt > max_q) begin
				max_q <= in_hgt;
			end
		end
	end

	// neighbour addresses, wrapping reads outside the image are replaced later
	always_comb begin
		case (cmd.rd_sel)
			NB_LEFT:  rd_addr = {row_q, col_q - COL_W'(1)};
			NB_RIGHT: rd_addr = {row_q, col_q + COL_W'(1)};
			NB_UP:    rd_addr = {row_q - ROW_W'(1), col_q};
			NB_DOWN:  rd_addr = {row_q + ROW_W'(1), col_q};
			default:  rd_addr = {row_q, col_q};
		endcase
	end

	// height store, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.accept && in_act == ACT_LOAD && in_bounds) begin
			mem[{in_row, in_col}] <= in_hgt;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// query position and edge flags
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			col_q    <= in_col;
			row_q    <= in_row;
			oob_q[0] <= (in_col == '0);
			oob_q[1] <= (7'(in_col) + 7'd1 >= cols_eff);
			oob_q[2] <= (in_row == '0);
			oob_q[3] <= (7'(in_row) + 7'd1 >= rows_eff);
		end
		if (cmd.cap_en) begin
			hgt_q[cmd.cap_sel] <= oob_q[cmd.cap_sel] ? max_q : rd_data_q;
		end
	end

	// slopes and their squares
	assign dx     = $signed({1'b0, hgt_q[NB_RIGHT]}) - $signed({1'b0, hgt_q[NB_LEFT]});
	assign dy     = $signed({1'b0, hgt_q[NB_DOWN]})  - $signed({1'b0, hgt_q[NB_UP]});
	assign dx_abs = dx[15] ? 15'(-dx) : dx[14:0];
	assign dy_abs = dy[15] ? 15'(-dy) : dy[14:0];

	always_ff @(posedge clk) begin
		if (cmd.mul_slope) begin
			a_mag_s1 <= 31'(scale_q) * 31'(dx_abs);
			b_mag_s1 <= 31'(scale_q) * 31'(dy_abs);
			a_pos_s1 <= ~dx[15] && (dx != 16'sd0);
			b_pos_s1 <= ~dy[15] && (dy != 16'sd0);
		end
		if (cmd.mul_sq) begin
			a_sq_s2 <= 62'(a_mag_s1) * 62'(a_mag_s1);
			b_sq_s2 <= 62'(b_mag_s1) * 62'(b_mag_s1);
		end
	end

	// square root, one result bit per step
	assign sq_trial = sq_r_q + sq_bit_q;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			sq_v_q   <= 64'(a_sq_s2) + 64'(b_sq_s2) + NORM_D_SQ;
			sq_r_q   <= '0;
			sq_bit_q <= 64'd1 << 62;
		end else if (cmd.sqrt_step) begin
			if (sq_v_q >= sq_trial) begin
				sq_v_q <= sq_v_q - sq_trial;
				sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// three dividers sharing one step sequence: (mag*65536 + r) / (2r)
	assign lane_mag[0] = a_mag_s1;
	assign lane_mag[1] = b_mag_s1;
	assign lane_mag[2] = 31'(NORM_D);

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			lane_num[l] = 48'({lane_mag[l], 16'd0}) + 48'(sq_r_q[32:0]);
			lane_t[l]   = {rem_q[l], quo_q[l][15]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dvs_q <= {sq_r_q[32:0], 1'b0};
			for (int l = 0; l < 3; l++) begin
				rem_q[l] <= 34'(lane_num[l][47:16]);
				quo_q[l] <= lane_num[l][15:0];
			end
		end else if (cmd.div_step) begin
			for (int l = 0; l < 3; l++) begin
				if (lane_t[l] >= 35'(dvs_q)) begin
					rem_q[l] <= 34'(lane_t[l] - 35'(dvs_q));
					quo_q[l] <= {quo_q[l][14:0], 1'b1};
				end else begin
					rem_q[l] <= lane_t[l][33:0];
					quo_q[l] <= {quo_q[l][14:0], 1'b0};
				end
			end
		end
	end

	// saturate, apply sign, output register
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			qs[l] = (quo_q[l] > 16'd32767) ? 15'h7fff : quo_q[l][14:0];
		end
	end

	assign nx = a_pos_s1 ? 16'd0 - {1'b0, qs[0]} : {1'b0, qs[0]};
	assign ny = b_pos_s1 ? 16'd0 - {1'b0, qs[1]} : {1'b0, qs[1]};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= {1'b0, qs[2], ny, nx};
		end
	end

	assign m_tdata = out_q;

endmodule

// ===== src/height_map_to_normal_map_unit.sv =====
// height_map_to_normal_map_unit: top level, joins controller and datapath
// depends on hmn_pkg, hmn_ctrl, hmn_dp
//
// input channel s_*: one beat per action; s_tuser carries the action
// (load pixel, query normal, clear maximum), s_tdata the pixel position and
// colour. loads, clears and ignored beats leave the block idle for the next beat.
// a query inside the image runs these steps from its beat to the result:
// four reads through the single read port of the height store, two
// multiply stages, 32 steps of the bit-serial square root and 16 steps of
// the three parallel dividers. a query outside the image gives no result.
// output channel m_*: one beat per query, held in an output register; the
// next input beat is taken while it waits, but a later query finishing
// while the receiver still stalls waits for the register to be taken.
// configuration: cfg_we/cfg_idx/cfg_wdata, to be written only while idle; the block does not enforce this.
// reset: registers take their defaults, maximum height cleared, no output
// pending; the height store is not cleared and must be loaded before use.
module height_map_to_normal_map_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// col[5:0], row[11:6], red[19:12], green[27:20], blue[35:28], zero fill
	input  logic [hmn_pkg::IN_DATA_W-1:0]       s_tdata,
	// action[1:0]
	input  logic [hmn_pkg::IN_USER_W-1:0]       s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// normal_x[15:0], normal_y[31:16], normal_z[46:32], zero fill
	output logic [hmn_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                cfg_we,
	input  logic [hmn_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [hmn_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import hmn_pkg::*;

	hmn_cmd_t cmd;
	hmn_sts_t sts;

	hmn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hmn_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== src/hmn_chk.sv =====
// hmn_chk: port-level checks of the normal map unit, bound to the top level
// depends on hmn_pkg, height_map_to_normal_map_unit
module hmn_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [hmn_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic [hmn_pkg::IN_USER_W-1:0]  s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [hmn_pkg::OUT_DATA_W-1:0] m_tdata
);
	import hmn_pkg::*;

	// a pending result beat is not withdrawn
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// a query at the origin is always inside the image and busies the block
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_QUERY && s_tdata[11:0] == 12'd0
		|=> !s_tready)
		else $error("query at origin did not start");

	// normal components stay within the saturated magnitude
	a_mag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] != 16'h8000 && m_tdata[31:16] != 16'h8000)
		else $error("normal component outside saturation range");

	// z is never zero since the z term dominates the length bound
	a_z: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[46:32] != 15'd0)
		else $error("normal z is zero");

endmodule

bind height_map_to_normal_map_unit hmn_chk u_hmn_chk (.*);

// ===== dv/height_map_to_normal_map_unit_tb.sv =====
// height_map_to_normal_map_unit_tb: self-checking stream testbench for the
// height map to normal map unit, with its own normal predictor
// depends on hmn_pkg and height_map_to_normal_map_unit
`timescale 1ns / 1ps

module height_map_to_normal_map_unit_tb;
	import hmn_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic [14:0] nz;
		logic [15:0] ny;
		logic [15:0] nx;
	} normal_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [IN_USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// predictor state
	logic [HGT_W-1:0] heights [DEPTH];
	bit written [DEPTH];
	int peak_height;
	int img_cols, img_rows;
	int scale;

	normal_t normals_due [$];
	int err_count = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;

	height_map_to_normal_map_unit u_top (.*);

	always #10 clk = ~clk;

	// receiver stall and result check
	always @(posedge clk) begin
		normal_t got, want;
		m_tready <= no_idle || ($urandom_range(99) >= 29);
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[46:0];
			if (normals_due.size() == 0) begin
				$error("unexpected result beat %h", m_tdata);
				err_count++;
			end else begin
				want = normals_due.pop_front();
				if (got.nx !== want.nx) begin
					$error("normal_x expected %h got %h", want.nx, got.nx);
					err_count++;
				end
				if (got.ny !== want.ny) begin
					$error("normal_y expected %h got %h", want.ny, got.ny);
					err_count++;
				end
				if (got.nz !== want.nz) begin
					$error("normal_z expected %h got %h", want.nz, got.nz);
					err_count++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned q15_of(longint unsigned mag, longint unsigned root);
		longint unsigned q;
		q = (mag * 65536 + root) / (2 * root);
		return (q > 32767) ? 32767 : q;
	endfunction

	// component is -v/root, two's complement in 16 bits
	function automatic logic [15:0] signed_comp(longint v, longint unsigned root);
		logic [15:0] q;
		q = 16'(q15_of((v < 0) ? -v : v, root));
		return (v > 0) ? -q : q;
	endfunction

	function automatic int hidx(int c, int r);
		return r * MAX_COLUMNS + c;
	endfunction

	function automatic normal_t calc_normal(int c, int r);
		int hl, hr, hu, hd;
		longint a, b;
		longint unsigned ua, ub, root;
		normal_t n;
		hl = (c > 0) ? heights[hidx(c - 1, r)] : peak_height;
		hr = (c + 1 < img_cols) ? heights[hidx(c + 1, r)] : peak_height;
		hu = (r > 0) ? heights[hidx(c, r - 1)] : peak_height;
		hd = (r + 1 < img_rows) ? heights[hidx(c, r + 1)] : peak_height;
		a = longint'(scale) * (hr - hl);
		b = longint'(scale) * (hd - hu);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		root = int_sqrt(ua * ua + ub * ub + NORM_D_SQ);
		n.nx = signed_comp(a, root);
		n.ny = signed_comp(b, root);
		n.nz = 15'(q15_of(NORM_D, root));
		return n;
	endfunction

	// every in-image neighbour of the pixel has been loaded
	function automatic bit neighbours_loaded(int c, int r);
		return (c == 0 || written[hidx(c - 1, r)]) &&
			(c + 1 >= img_cols || written[hidx(c + 1, r)]) &&
			(r == 0 || written[hidx(c, r - 1)]) &&
			(r + 1 >= img_rows || written[hidx(c, r + 1)]);
	endfunction

	// apply one accepted beat to the predictor
	function automatic void track_beat(logic [1:0] act, int c, int r, int red, int grn, int blu);
		int h;
		if (act == ACT_CLEAR) begin
			peak_height = 0;
		end else if (act != ACT_NONE && c < img_cols && r < img_rows) begin
			if (act == ACT_LOAD) begin
				h = 33 * red + 66 * grn + 11 * blu;
				heights[hidx(c, r)] = 15'(h);
				written[hidx(c, r)] = 1'b1;
				if (h > peak_height)
					peak_height = h;
			end else begin
				normals_due.insert(normals_due.size(), calc_normal(c, r));
			end
		end
	endfunction

	task automatic send_beat(logic [1:0] act, int c, int r, int red, int grn, int blu);
		if (!no_idle && $urandom_range(99) < 29) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 29);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {4'd0, blu[7:0], grn[7:0], red[7:0], r[5:0], c[5:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		track_beat(act, c, r, red, grn, blu);
	endtask

	// wait for all normals and the tail of any load or clear
	task automatic settle();
		s_tvalid <= 1'b0;
		while (normals_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_COLUMNS: img_cols = (value[6:0] == 0) ? 1 :
				(value[6:0] > MAX_COLUMNS) ? MAX_COLUMNS : value[6:0];
			CFG_ROWS: img_rows = (value[6:0] == 0) ? 1 :
				(value[6:0] > MAX_ROWS) ? MAX_ROWS : value[6:0];
			CFG_SCALE: scale = value[15:0];
			default: ;
		endcase
	endtask

	task automatic set_image(int cols, int rows, int slope);
		settle();
		write_reg(CFG_COLUMNS, cols);
		write_reg(CFG_ROWS, rows);
		write_reg(CFG_SCALE, slope);
	endtask

	// small image, edge fallback, clear, ignored beats, flat area
	task automatic test_directed();
		set_image(3, 3, 65535);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				send_beat(ACT_LOAD, c, r, (c == 2) ? 255 : 17 * c,
					(r == 2) ? 255 : 40 * r, (c + r == 4) ? 255 : 0);
		send_beat(ACT_QUERY, 1, 1, 0, 0, 0);
		send_beat(ACT_QUERY, 0, 0, 0, 0, 0);
		send_beat(ACT_QUERY, 2, 2, 0, 0, 0);
		// load outside the image must not raise the maximum
		send_beat(ACT_CLEAR, 0, 0, 0, 0, 0);
		send_beat(ACT_LOAD, 63, 63, 255, 255, 255);
		send_beat(ACT_QUERY, 0, 2, 255, 255, 255);
		send_beat(ACT_QUERY, 5, 1, 0, 0, 0);
		send_beat(ACT_NONE, 1, 1, 255, 255, 255);
		send_beat(ACT_LOAD, 1, 1, 255, 255, 255);
		send_beat(ACT_QUERY, 2, 1, 0, 0, 0);
		set_image(3, 3, 0);
		send_beat(ACT_QUERY, 1, 1, 0, 0, 0);
		send_beat(ACT_QUERY, 1, 2, 0, 0, 0);
	endtask

	// random beats on a window of the image, mostly queries that can be answered
	task automatic test_random(int cols, int rows, int slope, int beats, bit steady);
		int base_c, base_r, c, r, pick;
		logic [1:0] act;
		set_image(cols, rows, slope);
		no_idle = steady;
		base_c = $urandom_range(img_cols - 1);
		base_r = $urandom_range(img_rows - 1);
		for (int i = 0; i < beats; i++) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				c = $urandom_range(63);
				r = $urandom_range(63);
			end else begin
				c = base_c + $urandom_range(5);
				r = base_r + $urandom_range(5);
				if (c >= img_cols) c = img_cols - 1;
				if (r >= img_rows) r = img_rows - 1;
			end
			pick = $urandom_range(99);
			act = (pick < 3) ? ACT_CLEAR : (pick < 5) ? ACT_NONE :
				(pick < 45) ? ACT_LOAD : ACT_QUERY;
			if (act == ACT_QUERY && c < img_cols && r < img_rows && !neighbours_loaded(c, r))
				act = ACT_LOAD;
			if ($urandom_range(9) == 0)
				send_beat(act, c, r, $urandom_range(1) * 255,
					$urandom_range(1) * 255, $urandom_range(1) * 255);
			else
				send_beat(act, c, r, $urandom_range(255), $urandom_range(255),
					$urandom_range(255));
		end
		no_idle = 1'b0;
	endtask

	initial begin
		// reset asserted by an update so the falling edge is seen
		arst_n <= 1'b0;
		peak_height = 0;
		img_cols = COLUMNS_RST;
		img_rows = ROWS_RST;
		scale = SCALE_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(8, 8, 655, 140, 1'b0);
		test_random(1, 1, 65535, 40, 1'b0);
		test_random(64, 64, $urandom_range(65535), 120, 1'b0);
		test_random(0, 127, 30000, 50, 1'b0);
		test_random(127, 0, 1, 50, 1'b0);
		test_random(5, 2, 0, 60, 1'b0);
		test_random(16, 12, $urandom_range(65535), 120, 1'b1);
		test_random(64, 64, 655, 120, 1'b0);
		settle();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
